[hdl/ajq_pkg.sv]
`default_nettype none

package ajq_pkg;

  // Ring of conversion jobs; one slot always stays empty.
  localparam int QUEUE_DEPTH = 8;
  localparam int QW = $clog2(QUEUE_DEPTH);

  // Result buffer between the ring logic and the output port.
  localparam int RES_DEPTH = 4;
  localparam int RW = $clog2(RES_DEPTH);
  localparam int RCW = $clog2(RES_DEPTH + 1);

  typedef logic [QW-1:0] qidx_t;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_DONE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_START  = 2'd0,
    EV_DONE   = 2'd1,
    EV_REJECT = 2'd2
  } event_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  ch;
    logic [7:0]  tag;
    logic [9:0]  val;
    logic        last;
  } result_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  typedef struct packed {
    logic busy;
    logic empty;
  } ring_stat_t;

  function automatic qidx_t next_slot(input qidx_t i);
    qidx_t n;
    n = i + qidx_t'(1);
    if (i == qidx_t'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[hdl/adc_conversion_job_queue.sv]
`default_nettype none

// Channel   Dir  Bits (lowest first)                              Marks
// in_       in   tuser: opcode; tdata: channel_select[7:0],       tvalid/tready
//                job_tag[15:8], sample[25:16], rest ignored
// out_      out  tuser: event_res; tdata: start_channel[7:0],     tvalid/tready,
//                done_tag[15:8], done_value[25:16], rest zero      tlast
//
// An accepted beat lands in an input register; the ring update and its results
// are computed combinationally from there and written into a four-entry result
// buffer, which feeds the output port. A new input beat can be taken every
// cycle while the buffer has room for two results; a completion that also
// starts the next job produces two output beats, so the output port (one beat
// a cycle while out_tready is high) sets the sustained rate. rst_n is
// synchronous and clears pointers, flags and the result buffer; the job stores
// need no reset. Output stalls back up into the input register and then drop
// in_tready.

module adc_conversion_job_queue
  import ajq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // channel_select, job_tag, sample
  input  wire logic        in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // start_channel, done_tag, done_value
  output logic [1:0]       out_tuser,  // event_res
  output logic             out_tlast
);

  // Input register holding one beat until the ring logic takes it.
  logic       in_valid_r, in_valid_nxt;
  op_t        in_op_r;
  logic [7:0] in_ch_r;
  logic [7:0] in_tag_r;
  logic [9:0] in_smp_r;

  logic           fire;
  logic           in_acc;
  logic           out_pop;
  result_t        res0, res1, res_head;
  push_t          push;
  ring_stat_t     ring_st;
  logic [RCW-1:0] res_cnt;

  // The ring logic only runs when the buffer can absorb both possible results.
  assign fire      = in_valid_r && (res_cnt <= RCW'(RES_DEPTH - 2));
  assign in_tready = !in_valid_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_op_r  <= op_t'(in_tuser);
      in_ch_r  <= in_tdata[7:0];
      in_tag_r <= in_tdata[15:8];
      in_smp_r <= in_tdata[25:16];
    end
  end

  ajq_ring u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .op     (in_op_r),
    .chan   (in_ch_r),
    .tag    (in_tag_r),
    .sample (in_smp_r),
    .res0   (res0),
    .res1   (res1),
    .push   (push),
    .stat   (ring_st)
  );

  ajq_res_fifo u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .res0  (res0),
    .res1  (res1),
    .pop   (out_pop),
    .head  (res_head),
    .count (res_cnt)
  );

  assign out_tvalid = (res_cnt != '0);
  assign out_pop    = out_tvalid && out_tready;
  assign out_tuser  = res_head.ev;
  assign out_tdata  = {6'd0, res_head.val, res_head.tag, res_head.ch};
  assign out_tlast  = res_head.last;

`ifndef SYNTHESIS
  // The buffer never overfills: the ring logic waits for room for two results.
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt <= RCW'(RES_DEPTH))
    else $error("result buffer overflow");

  // A held input beat is never dropped without being processed.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !fire |=> in_valid_r)
    else $error("input beat lost");

  // A conversion is running exactly when jobs are pending.
  a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
    ring_st.busy == !ring_st.empty)
    else $error("busy flag out of step with ring");

  // A second result is only pushed together with the first, while an item is processed.
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0 && fire)
    else $error("second result without first");
`endif

endmodule

`default_nettype wire

[hdl/ajq_ring.sv]
`default_nettype none

module ajq_ring
  import ajq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire op_t        op,
  input  wire logic [7:0] chan,
  input  wire logic [7:0] tag,
  input  wire logic [9:0] sample,
  output result_t         res0,
  output result_t         res1,
  output push_t           push,
  output ring_stat_t      stat
);

  logic [7:0] channel_store [QUEUE_DEPTH];
  logic [7:0] tag_store [QUEUE_DEPTH];

  qidx_t head_r, head_nxt;
  qidx_t tail_r, tail_nxt;
  logic  busy_r, busy_nxt;
  logic  wr_en;

  qidx_t head_inc, tail_inc;
  logic  full, empty;

  assign head_inc = next_slot(head_r);
  assign tail_inc = next_slot(tail_r);
  assign full     = (head_inc == tail_r);
  assign empty    = (head_r == tail_r);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    busy_nxt = busy_r;
    wr_en    = 1'b0;
    res0     = '{ev: EV_START, ch: '0, tag: '0, val: '0, last: 1'b0};
    res1     = '{ev: EV_START, ch: '0, tag: '0, val: '0, last: 1'b1};
    push     = '0;
    if (fire) begin
      unique case (op)
        OP_ADD: begin
          if (full) begin
            res0.ev    = EV_REJECT;
            res0.last  = 1'b1;
            push.push0 = 1'b1;
          end else begin
            wr_en    = 1'b1;
            head_nxt = head_inc;
            if (!busy_r) begin
              // Idle means the ring was empty, so the new job is the tail.
              busy_nxt   = 1'b1;
              res0.ch    = chan;
              res0.last  = 1'b1;
              push.push0 = 1'b1;
            end
          end
        end
        OP_DONE: begin
          if (!empty) begin
            tail_nxt   = tail_inc;
            res0.ev    = EV_DONE;
            res0.tag   = tag_store[tail_r];
            res0.val   = sample;
            push.push0 = 1'b1;
            if (head_r != tail_inc) begin
              res1.ch    = channel_store[tail_inc];
              push.push1 = 1'b1;
            end else begin
              busy_nxt  = 1'b0;
              res0.last = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      channel_store[head_r] <= chan;
      tag_store[head_r]     <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      busy_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign stat = '{busy: busy_r, empty: empty};

endmodule

`default_nettype wire

[hdl/ajq_res_fifo.sv]
`default_nettype none

module ajq_res_fifo
  import ajq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire push_t    push,
  input  wire result_t  res0,
  input  wire result_t  res1,
  input  wire logic     pop,
  output result_t       head,
  output logic [RCW-1:0] count
);

  result_t mem [RES_DEPTH];

  logic [RW-1:0]  wr_r, wr_nxt;
  logic [RW-1:0]  rd_r, rd_nxt;
  logic [RCW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0]  wr_p1;

  assign wr_p1 = wr_r + RW'(1);

  always_comb begin
    wr_nxt  = wr_r + RW'(push.push0) + RW'(push.push1);
    rd_nxt  = rd_r + RW'(pop);
    cnt_nxt = cnt_r + RCW'(push.push0) + RCW'(push.push1) - RCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_r] <= res0;
    end
    if (push.push1) begin
      mem[wr_p1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head  = mem[rd_r];
  assign count = cnt_r;

endmodule

`default_nettype wire

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ajq_pkg::*;

  // Run length and watchdog. The slowest correct run is about 420 beats, each
  // with up to two results behind a throttled receiver and a random sender gap,
  // plus one long output hold-off: well under the watchdog limit.
  localparam int RANDOM_BEATS  = 400;
  localparam int LIMIT_CYCLES  = 100000;
  localparam int TAIL_CYCLES   = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_TRIGGER  = 150;
  localparam int DRAIN_AT_BEAT = 250;

  // One queued input beat. A drain mark makes the sender stop until every
  // result it has caused so far has come out.
  typedef struct {
    bit         drain_mark;
    op_t        op;
    logic [7:0] ch;
    logic [7:0] tag;
    logic [9:0] smp;
  } job_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // channel_select, job_tag, sample
  logic        in_tuser = 1'b0; // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // start_channel, done_tag, done_value
  logic [1:0]  out_tuser;       // event_res
  logic        out_tlast;

  adc_conversion_job_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  job_beat_t beat_q[$];
  result_t   pending_results[$];

  // Shadow of the job ring: slot contents, write and read slots, and whether a
  // conversion is currently running.
  logic [7:0]  shadow_chan[QUEUE_DEPTH];
  logic [7:0]  shadow_tag[QUEUE_DEPTH];
  int unsigned shadow_wr = 0;
  int unsigned shadow_rd = 0;
  bit          shadow_busy = 1'b0;

  // Bookkeeping shared by the processes.
  bit in_took = 1'b0;
  int accepted_beats = 0;
  int checked_beats = 0;
  int err_count = 0;
  int cycles = 0;
  int n_add = 0, n_reject = 0, n_done = 0, n_empty_done = 0, n_start = 0;
  bit hold_done = 1'b0;

  function automatic int unsigned ring_advance(input int unsigned slot);
    return (slot + 1) % QUEUE_DEPTH;
  endfunction

  function automatic result_t job_result(input event_t ev, input logic [7:0] ch,
                                         input logic [7:0] tag, input logic [9:0] val);
    result_t r;
    r.ev = ev;
    r.ch = ch;
    r.tag = tag;
    r.val = val;
    r.last = 1'b0;
    return r;
  endfunction

  // Applies one accepted beat to the shadow ring and appends the result beats
  // it causes. The final one of them carries last.
  task automatic predict_job_queue(input op_t op, input logic [7:0] ch,
                                   input logic [7:0] tag, input logic [9:0] smp);
    int first;
    first = pending_results.size();
    if (op == OP_ADD) begin
      n_add++;
      if (ring_advance(shadow_wr) == shadow_rd) begin
        // The ring already holds its maximum; the job is dropped.
        pending_results.push_back(job_result(EV_REJECT, 8'd0, 8'd0, 10'd0));
        n_reject++;
      end else begin
        shadow_chan[shadow_wr] = ch;
        shadow_tag[shadow_wr] = tag;
        shadow_wr = ring_advance(shadow_wr);
        if (!shadow_busy) begin
          // Nothing was converting, so the new job starts at once.
          shadow_busy = 1'b1;
          pending_results.push_back(job_result(EV_START, shadow_chan[shadow_rd], 8'd0, 10'd0));
          n_start++;
        end
      end
    end else if (shadow_wr != shadow_rd) begin
      pending_results.push_back(job_result(EV_DONE, 8'd0, shadow_tag[shadow_rd], smp));
      shadow_rd = ring_advance(shadow_rd);
      n_done++;
      if (shadow_wr != shadow_rd) begin
        pending_results.push_back(job_result(EV_START, shadow_chan[shadow_rd], 8'd0, 10'd0));
        n_start++;
      end else begin
        shadow_busy = 1'b0;
      end
    end else begin
      // A completion with no job waiting is ignored by the block.
      n_empty_done++;
    end
    if (pending_results.size() > first) begin
      pending_results[pending_results.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("result beat %0d: %s expected %0d, got %0d", checked_beats, name, exp_val, act_val);
      err_count++;
    end
  endtask

  // Monitor: takes input beats into the predictor and output beats against the
  // oldest expectation, both at the rising edge.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n) begin
      in_took = in_tvalid && in_tready;
      if (in_took) begin
        predict_job_queue(op_t'(in_tuser), in_tdata[7:0], in_tdata[15:8], in_tdata[25:16]);
        accepted_beats++;
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: event_res %0d, tdata 0x%08h", out_tuser, out_tdata);
          err_count++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("event_res", exp_r.ev, out_tuser);
          check_field("start_channel", exp_r.ch, out_tdata[7:0]);
          check_field("done_tag", exp_r.tag, out_tdata[15:8]);
          check_field("done_value", exp_r.val, out_tdata[25:16]);
          check_field("tdata_pad", 0, out_tdata[31:26]);
          check_field("last", exp_r.last, out_tlast);
        end
        checked_beats++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycles, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sender: bursts of random length separated by random gaps. A beat stays on
  // the bus until it has been taken; the next one is put up at the falling edge.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    bit          nv;
    logic [31:0] nd;
    logic        nu;
    job_beat_t   b;
    nv = in_tvalid;
    nd = in_tdata;
    nu = in_tuser;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_tvalid || in_took) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (beat_q.size() != 0) begin
        if (beat_q[0].drain_mark) begin
          if (pending_results.size() == 0) begin
            void'(beat_q.pop_front());
          end
        end else begin
          b = beat_q.pop_front();
          nv = 1'b1;
          nd = {6'd0, b.smp, b.tag, b.ch};
          nu = b.op;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // A quarter of the bursts follow the previous one back to back.
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    in_tvalid <= nv;
    in_tdata <= nd;
    in_tuser <= nu;
  end

  // Receiver: changes its stall pattern at random intervals, and once, after
  // enough beats have gone in, holds off for a long stretch so that the result
  // buffer fills and the block stops taking input.
  int hold_left = 0;
  int rx_phase = 0;
  int rx_mode = 0;
  int rx_tick = 0;

  always @(negedge clk) begin
    bit rdy;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!hold_done && accepted_beats >= HOLD_TRIGGER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rdy = 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_phase = $urandom_range(20, 80);
      end else begin
        rx_phase--;
      end
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = (rx_tick % 3 == 0);
        default: rdy = ($urandom_range(0, 4) != 0);
      endcase
      rx_tick++;
    end
    out_tready <= rdy;
  end

  task automatic queue_beat(input op_t op, input logic [7:0] ch, input logic [7:0] tag,
                            input logic [9:0] smp);
    job_beat_t b;
    b.drain_mark = 1'b0;
    b.op = op;
    b.ch = ch;
    b.tag = tag;
    b.smp = smp;
    beat_q.push_back(b);
  endtask

  task automatic queue_drain;
    job_beat_t b;
    b.drain_mark = 1'b1;
    b.op = OP_ADD;
    b.ch = '0;
    b.tag = '0;
    b.smp = '0;
    beat_q.push_back(b);
  endtask

  initial begin
    int seg_left;
    int add_pct;
    // Directed part. A completion on an empty ring, then seven jobs to fill the
    // ring (the first starts at once, the rest queue), an add into the full
    // ring, seven completions that drain it (the last one starts nothing), a
    // completion on the empty ring again, and one job run start to finish.
    queue_beat(OP_DONE, 8'h00, 8'h00, 10'h3FF);
    queue_beat(OP_ADD, 8'h00, 8'h00, 10'h000);
    queue_beat(OP_ADD, 8'hFF, 8'hFF, 10'h3FF);
    queue_beat(OP_ADD, 8'h55, 8'hAA, 10'h155);
    queue_beat(OP_ADD, 8'hAA, 8'h55, 10'h2AA);
    queue_beat(OP_ADD, 8'h01, 8'h02, 10'h001);
    queue_beat(OP_ADD, 8'h03, 8'h04, 10'h200);
    queue_beat(OP_ADD, 8'h80, 8'h01, 10'h000);
    queue_beat(OP_ADD, 8'h7F, 8'hFE, 10'h3FF);
    queue_beat(OP_DONE, 8'hFF, 8'hFF, 10'h000);
    queue_beat(OP_DONE, 8'h00, 8'h00, 10'h3FF);
    queue_beat(OP_DONE, 8'h00, 8'h00, 10'h155);
    queue_beat(OP_DONE, 8'h00, 8'h00, 10'h2AA);
    queue_beat(OP_DONE, 8'h00, 8'h00, 10'h001);
    queue_beat(OP_DONE, 8'h00, 8'h00, 10'h200);
    queue_beat(OP_DONE, 8'h00, 8'h00, 10'h1FF);
    queue_beat(OP_DONE, 8'hFF, 8'hFF, 10'h3FF);
    queue_beat(OP_ADD, 8'h12, 8'h34, 10'h000);
    queue_beat(OP_DONE, 8'h00, 8'h00, 10'h0AB);
    queue_drain();

    // Random part: segments with their own mix of adds and completions, so the
    // ring swings between empty, partly full and full, and the indexes wrap.
    seg_left = 0;
    add_pct = 50;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (seg_left == 0) begin
        case ($urandom_range(0, 3))
          0: add_pct = 25;
          1: add_pct = 50;
          2: add_pct = 65;
          default: add_pct = 85;
        endcase
        seg_left = $urandom_range(15, 40);
      end
      seg_left--;
      if (i == DRAIN_AT_BEAT) begin
        queue_drain();
      end
      queue_beat(($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_DONE,
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 10'($urandom_range(0, 1023)));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every beat has gone in and every result has come out, then
    // give the block time to show any stray result.
    while (beat_q.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d input beats: %0d adds (%0d turned away by a full ring), %0d completions,",
             accepted_beats, n_add, n_reject, n_done);
    $display("%0d completions on an empty ring, %0d starts; %0d result beats checked in %0d cycles.",
             n_empty_done, n_start, checked_beats, cycles);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ajq_pkg.sv
hdl/ajq_ring.sv
hdl/ajq_res_fifo.sv
hdl/adc_conversion_job_queue.sv
dv/testbench.sv
